/* hw/rtl/sstm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstm_pkg
// Types and constants shared by the sorted timer list block.
// ----------------------------------------------------------------------------
package sstm_pkg;

  typedef enum logic [2:0] {
    CMD_ALLOC = 3'd0,
    CMD_FREE  = 3'd1,
    CMD_INIT  = 3'd2,
    CMD_ARM   = 3'd3,
    CMD_TICK  = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_ALLOC = 2'd1,
    ST_NONE  = 2'd2,
    ST_FIRED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    MODE_FREE    = 2'd0,
    MODE_ALLOC   = 2'd1,
    MODE_RUNNING = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UNLINK,
    S_INSERT,
    S_FIRE,
    S_DONE
  } state_t;

  localparam logic [31:0] NO_DEADLINE = 32'hffff_ffff;

  typedef struct packed {
    logic [2:0]  command;
    logic [4:0]  slot;
    logic [31:0] delay;
    logic [1:0]  queue_sel;
    logic [7:0]  payload;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] slot_out;
    logic [1:0] queue_out;
    logic [7:0] payload_out;
    logic       last;
  } out_item_t;

endpackage

/* hw/rtl/sstm_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstm_fifo
// Small register queue used between the front and back parts and at the output.
// ----------------------------------------------------------------------------
module sstm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (AW+1)'(do_wr) - (AW+1)'(do_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end
endmodule

/* hw/rtl/sstm_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstm_engine
// Back part: keeps slot modes, deadlines and the sorted list, walks the list
// one entry a cycle for unlink, insert and expiry; expiry waits while the result queue is full.
// ----------------------------------------------------------------------------
module sstm_engine
  import sstm_pkg::*;
#(
  parameter int NUM_TIMERS = 32,
  parameter int NUM_QUEUES = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  input  in_item_t  cmd,
  output logic      cmd_pop,
  output logic      res_push,
  output out_item_t res,
  input  logic      res_full
);
  localparam int SW = $clog2(NUM_TIMERS);
  localparam logic [5:0] END_MARK = 6'd63;

  state_t state;
  state_t state_next;

  logic [31:0] tick_count;
  logic [1:0]  slot_mode [NUM_TIMERS];
  logic [31:0] deadline  [NUM_TIMERS];
  logic [1:0]  dq        [NUM_TIMERS];
  logic [7:0]  dp        [NUM_TIMERS];
  logic [5:0]  link      [NUM_TIMERS];
  logic [5:0]  head;

  in_item_t    cur_cmd;
  logic [5:0]  prev;
  logic [5:0]  cur;
  logic [31:0] new_dl;
  logic        fired_any;

  logic          ok;
  logic [SW-1:0] sidx;
  logic [SW-1:0] cidx;
  logic [SW-1:0] pidx;
  logic [SW-1:0] hidx;
  logic          cur_valid;
  logic          head_valid;
  logic [SW:0]   free_idx;
  logic          head_fires;

  assign ok         = {1'b0, cur_cmd.slot} < 6'(NUM_TIMERS);
  assign sidx       = cur_cmd.slot[SW-1:0];
  assign cidx       = cur[SW-1:0];
  assign pidx       = prev[SW-1:0];
  assign hidx       = head[SW-1:0];
  assign cur_valid  = cur < 6'(NUM_TIMERS);
  assign head_valid = head < 6'(NUM_TIMERS);
  assign head_fires = head_valid && (deadline[hidx] <= tick_count);

  always_comb begin
    free_idx = (SW+1)'(NUM_TIMERS);
    for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
      if (slot_mode[i] == MODE_FREE) begin
        free_idx = (SW+1)'(i);
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          state_next = S_DONE;
          if (cmd.command == CMD_TICK) begin
            state_next = S_FIRE;
          end else if ((cmd.command == CMD_FREE || cmd.command == CMD_ARM)
                       && ({1'b0, cmd.slot} < 6'(NUM_TIMERS))) begin
            if (slot_mode[cmd.slot[SW-1:0]] == MODE_RUNNING) begin
              state_next = S_UNLINK;
            end else if (cmd.command == CMD_ARM
                         && slot_mode[cmd.slot[SW-1:0]] != MODE_FREE) begin
              state_next = S_INSERT;
            end
          end
        end
      end
      S_UNLINK: begin
        if (!cur_valid || cidx == sidx) begin
          state_next = (cur_cmd.command == CMD_ARM) ? S_INSERT : S_DONE;
        end
      end
      S_INSERT: begin
        if (!cur_valid || new_dl <= deadline[cidx]) begin
          state_next = S_DONE;
        end
      end
      S_FIRE: begin
        if (!res_full && !head_fires) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!res_full) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop  = (state == S_IDLE) && cmd_valid;
    res_push = 1'b0;
    res      = '0;
    unique case (state)
      S_FIRE: begin
        if (head_fires) begin
          res_push        = !res_full;
          res.status      = ST_FIRED;
          res.slot_out    = 5'(head);
          res.queue_out   = dq[hidx];
          res.payload_out = dp[hidx];
          res.last        = !(link[hidx] < 6'(NUM_TIMERS)
                              && deadline[link[hidx][SW-1:0]] <= tick_count);
        end
      end
      S_DONE: begin
        res_push = !fired_any && !res_full;
        res.last = 1'b1;
        if (cur_cmd.command == CMD_ALLOC) begin
          if (free_idx < (SW+1)'(NUM_TIMERS)) begin
            res.status   = ST_ALLOC;
            res.slot_out = 5'(free_idx);
          end else begin
            res.status = ST_NONE;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      tick_count <= '0;
      head       <= END_MARK;
      fired_any  <= 1'b0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        slot_mode[i] <= MODE_FREE;
      end
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cur_cmd   <= cmd;
            prev      <= END_MARK;
            cur       <= head;
            fired_any <= 1'b0;
            new_dl    <= cmd.delay + tick_count;
            if (cmd.command == CMD_TICK) begin
              tick_count <= tick_count + 1'b1;
            end
          end
        end
        S_UNLINK: begin
          if (!cur_valid) begin
            prev <= END_MARK;
            cur  <= head;
          end else if (cidx == sidx) begin
            if (prev == END_MARK) begin
              head <= link[cidx];
            end else begin
              link[pidx] <= link[cidx];
            end
            prev <= END_MARK;
            cur  <= (prev == END_MARK) ? link[cidx] : head;
          end else begin
            prev <= cur;
            cur  <= link[cidx];
          end
        end
        S_INSERT: begin
          if (!cur_valid || new_dl <= deadline[cidx]) begin
            link[sidx]      <= cur_valid ? cur : END_MARK;
            deadline[sidx]  <= new_dl;
            slot_mode[sidx] <= MODE_RUNNING;
            if (prev == END_MARK) begin
              head <= {1'b0, cur_cmd.slot};
            end else begin
              link[pidx] <= {1'b0, cur_cmd.slot};
            end
          end else begin
            prev <= cur;
            cur  <= link[cidx];
          end
        end
        S_FIRE: begin
          if (!res_full && head_fires) begin
            slot_mode[hidx] <= MODE_ALLOC;
            head            <= (link[hidx] < 6'(NUM_TIMERS)) ? link[hidx] : END_MARK;
            fired_any       <= 1'b1;
          end
        end
        S_DONE: begin
          if (!res_full) begin
            if (cur_cmd.command == CMD_ALLOC && free_idx < (SW+1)'(NUM_TIMERS)) begin
              slot_mode[free_idx[SW-1:0]] <= MODE_ALLOC;
            end
            if (cur_cmd.command == CMD_FREE && ok) begin
              slot_mode[sidx] <= MODE_FREE;
            end
            if (cur_cmd.command == CMD_INIT && ok) begin
              dq[sidx] <= ({3'b0, cur_cmd.queue_sel} < 5'(NUM_QUEUES))
                          ? cur_cmd.queue_sel : 2'(NUM_QUEUES - 1);
              dp[sidx] <= cur_cmd.payload;
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule

/* hw/rtl/sorted_software_timer_manager_core.sv */
`timescale 1ns / 1ps
// commands: alloc, init and unknown commands go straight to their result; arm and free
// walk the list entry by entry as needed, unlink then insert for arm; tick fires each
// due slot from the head of the list, and gives a done item only if no slot fired
// throughput: one item at a time through the list walker
// reset: rst synchronous active high; all slots free, list empty, tick count 0
// ----------------------------------------------------------------------------
// sorted_software_timer_manager_core
// Sorted one-shot timer list: command queue, list engine, result queue.
// ----------------------------------------------------------------------------
module sorted_software_timer_manager_core
  import sstm_pkg::*;
#(
  parameter int NUM_TIMERS = 32,
  parameter int NUM_QUEUES = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  in_item_t  in_item,
  output logic      full,
  input  logic      pop,
  output out_item_t out_item,
  output logic      empty
);
  logic      cq_empty;
  logic      cq_pop;
  in_item_t  cq_data;
  logic      rq_push;
  logic      rq_full;
  out_item_t rq_data;

  sstm_fifo #(.WIDTH($bits(in_item_t)), .DEPTH(2)) u_cmd_q (
    .clk(clk), .rst(rst), .wr_en(push), .wr_data(in_item), .full(full),
    .rd_en(cq_pop), .rd_data(cq_data), .empty(cq_empty)
  );

  sstm_engine #(.NUM_TIMERS(NUM_TIMERS), .NUM_QUEUES(NUM_QUEUES)) u_engine (
    .clk(clk), .rst(rst), .cmd_valid(!cq_empty), .cmd(cq_data), .cmd_pop(cq_pop),
    .res_push(rq_push), .res(rq_data), .res_full(rq_full)
  );

  sstm_fifo #(.WIDTH($bits(out_item_t)), .DEPTH(2)) u_res_q (
    .clk(clk), .rst(rst), .wr_en(rq_push), .wr_data(rq_data), .full(rq_full),
    .rd_en(pop), .rd_data(out_item), .empty(empty)
  );

  a_no_push_lost: assert property (@(posedge clk) disable iff (rst)
    rq_push |-> !rq_full) else $error("result written into full queue");
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    cq_pop |-> !cq_empty) else $error("command read from empty queue");
  a_fire_status: assert property (@(posedge clk) disable iff (rst)
    (rq_push && rq_data.status == ST_FIRED) |-> !rq_full)
    else $error("fired item dropped");
endmodule
